// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every cycle outside reset
`define CHK_IMPLY(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");
// Next-cycle implication
`define CHK_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");
`endif

// ===== hdl/rlru_pkg.sv =====
// ----------------------------------------------------------------------------
// rlru_pkg
// Shared types and codes of the region LRU replacement core.
// ----------------------------------------------------------------------------
package rlru_pkg;
  localparam int unsigned REQ_W = 3;
  localparam int unsigned WAYF_W = 4;
  localparam int unsigned STATE_W = 3;
  localparam int unsigned STREAM_W = 8;
  localparam int unsigned EPOCH_W = 2;
  localparam int unsigned DIST_W = 32;
  localparam logic [DIST_W-1:0] DIST_MAX = 32'hffffffff;
  localparam logic [DIST_W-1:0] REACH_LIMIT = 32'd4096;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = 2'd3;

  typedef enum logic [REQ_W-1:0] {
    REQ_FIND = 3'd0, REQ_FILL = 3'd1, REQ_ACCESS = 3'd2,
    REQ_REPLACE = 3'd3, REQ_SETSTATE = 3'd4, REQ_GET = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_WALK, BK_DECIDE, BK_REMOVE, BK_INSERT, BK_OUT
  } bk_state_t;
endpackage

// ===== hdl/rlru_front.sv =====
// ----------------------------------------------------------------------------
// rlru_front
// Accepts requests and queues them for the back end.
// ----------------------------------------------------------------------------
module rlru_front #(
  parameter int unsigned QW = 1
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [QW-1:0] in_data,
  output logic q_valid,
  input  logic q_pop,
  output logic [QW-1:0] q_data
);
  import rlru_pkg::*;
  localparam int unsigned QD = 2;
  logic [QW-1:0] mem_r [QD];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push;

  assign in_stall = (cnt_r == 2'(QD));
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_data;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule

// ===== hdl/rlru_back.sv =====
// ----------------------------------------------------------------------------
// rlru_back
// Executes queued requests against the set: list walks and updates.
// ----------------------------------------------------------------------------
module rlru_back #(
  parameter int unsigned TAG_WIDTH = 48,
  parameter int unsigned WAYS = 16,
  parameter int unsigned STRIDE_LIMIT_LOG2 = 10,
  parameter int unsigned QW = 1
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_pop,
  input  logic [QW-1:0] q_data,
  input  logic [rlru_pkg::STREAM_W-1:0] source_stream,
  input  logic replace_on_miss,
  output logic out_valid,
  input  logic out_stall,
  output logic out_found,
  output logic [rlru_pkg::WAYF_W-1:0] out_result_way,
  output logic [TAG_WIDTH-1:0] out_tag,
  output logic [TAG_WIDTH-1:0] out_region_end,
  output logic [rlru_pkg::STATE_W-1:0] out_state,
  output logic [rlru_pkg::STREAM_W-1:0] out_stream,
  output logic out_dirty,
  output logic [rlru_pkg::EPOCH_W-1:0] out_epoch
);
  import rlru_pkg::*;
  localparam int unsigned WI = $clog2(WAYS);
  localparam int unsigned CW = $clog2(WAYS + 1);

  logic [TAG_WIDTH-1:0] rs_r [WAYS];
  logic [TAG_WIDTH-1:0] re_r [WAYS];
  logic [STATE_W-1:0] st_r [WAYS];
  logic [STREAM_W-1:0] sm_r [WAYS];
  logic dt_r [WAYS];
  logic [EPOCH_W-1:0] ep_r [WAYS];
  logic [WI-1:0] lru_r [WAYS];
  logic [WI-1:0] ff_r [WAYS];
  logic [CW-1:0] lc_r, fc_r;
  logic [CW-1:0] rc_r;
  logic rm_r;

  bk_state_t st_q, st_nxt;
  logic [CW-1:0] i_r;
  logic [DIST_W-1:0] dist_r;
  logic nv_r, hit_r;
  logic [WI-1:0] near_r, hw_r;
  logic [REQ_W-1:0] rq;
  logic [TAG_WIDTH-1:0] tg;
  logic [WAYF_W-1:0] wy;
  logic [STATE_W-1:0] ns;
  logic [STREAM_W-1:0] nstm, rstm;
  logic dmd, spl;
  logic ok;
  logic [WI-1:0] w;
  // per-request scratch for list edits
  logic rem_lru_r, rem_ff_r, ins_lru_r, app_ff_r, inff_r, inlru_r;
  logic [CW-1:0] pos_r;
  // prefix marks: position k at or after the matching entry
  logic pre_ff [WAYS];
  logic lru_past [WAYS];

  assign {rq, tg, wy, ns, nstm, rstm, dmd, spl} = q_data;
  assign ok = {28'd0, wy} < 32'(WAYS);
  assign w = WI'(wy);

  function automatic logic [DIST_W-1:0] sdist(input logic [TAG_WIDTH-1:0] a,
                                              input logic [TAG_WIDTH-1:0] b);
    logic [TAG_WIDTH-1:0] d;
    d = (a >= b) ? a - b : b - a;
    if (TAG_WIDTH > DIST_W && (d >> DIST_W) != '0) return DIST_MAX;
    return DIST_W'(d);
  endfunction

  logic [WI-1:0] cw;
  logic [DIST_W-1:0] d1, d2;
  assign cw = lru_r[i_r[WI-1:0]];
  assign d1 = sdist(rs_r[cw], tg);
  assign d2 = sdist(re_r[cw], tg);

  always_comb begin
    st_nxt = st_q;
    case (st_q)
      BK_IDLE: if (q_valid) st_nxt = (rq == REQ_FIND) ? BK_WALK : BK_REMOVE;
      BK_WALK: if (i_r >= lc_r || hit_r) st_nxt = BK_DECIDE;
      BK_DECIDE: st_nxt = BK_OUT;
      BK_REMOVE: st_nxt = BK_INSERT;
      BK_INSERT: st_nxt = BK_OUT;
      BK_OUT: if (!out_stall) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    out_valid = (st_q == BK_OUT);
    q_pop = (st_q == BK_OUT) && !out_stall;
  end

  logic [TAG_WIDTH-1:0] span;
  logic [TAG_WIDTH:0] sum;
  always_comb begin
    span = re_r[near_r] - rs_r[near_r];
    sum = {1'b0, span} + (TAG_WIDTH+1)'(dist_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_q <= BK_IDLE;
      lc_r <= '0; fc_r <= CW'(WAYS);
      rc_r <= '0; rm_r <= 1'b0;
      for (int k = 0; k < WAYS; k++) begin
        st_r[k] <= '0; dt_r[k] <= 1'b0; ep_r[k] <= '0; ff_r[k] <= WI'(k);
      end
    end else begin
      st_q <= st_nxt;
      case (st_q)
        BK_IDLE: if (q_valid) begin
          i_r <= '0; dist_r <= DIST_MAX; nv_r <= 1'b0; hit_r <= 1'b0;
          out_found <= 1'b0; out_result_way <= '0;
          out_tag <= '0; out_region_end <= '0; out_state <= '0;
          out_stream <= '0; out_dirty <= 1'b0; out_epoch <= '0;
          rem_lru_r <= 1'b0; rem_ff_r <= 1'b0; ins_lru_r <= 1'b0; app_ff_r <= 1'b0;
          inff_r <= 1'b0; inlru_r <= 1'b0; pos_r <= '0;
          for (int k = 0; k < WAYS; k++) begin
            if (CW'(k) < fc_r && ff_r[k] == w) begin inff_r <= 1'b1; end
            if (CW'(k) < lc_r && lru_r[k] == w) begin inlru_r <= 1'b1; end
          end
        end
        BK_WALK: if (!(i_r >= lc_r || hit_r)) begin
          if (dist_r > d1 || dist_r > d2) begin
            dist_r <= (d2 < d1) ? d2 : d1; near_r <= cw; nv_r <= 1'b1;
          end
          if (tg >= rs_r[cw] && tg <= re_r[cw]) begin hit_r <= 1'b1; hw_r <= cw; end
          i_r <= i_r + 1'b1;
        end
        BK_DECIDE: begin
          if (hit_r) begin
            out_found <= 1'b1; out_result_way <= WAYF_W'(hw_r);
          end else if (fc_r == '0 && nv_r && lc_r != '0 && rstm == source_stream) begin
            if (rc_r < CW'(WAYS) && !rm_r) begin
              if (dist_r > REACH_LIMIT) begin
                if (near_r == lru_r[0] || near_r == lru_r[WI'(lc_r - 1'b1)]) begin
                  rc_r <= rc_r + 1'b1;
                  if (rc_r + 1'b1 == CW'(WAYS)) rm_r <= 1'b1;
                end else if (rc_r != '0) rc_r <= rc_r - 1'b1;
              end
              if (!replace_on_miss ||
                  sum < ((TAG_WIDTH+1)'(1) << STRIDE_LIMIT_LOG2)) begin
                out_found <= 1'b1; out_result_way <= WAYF_W'(near_r);
              end
            end else begin
              if (rc_r != '0) rc_r <= rc_r - 1'b1;
              if (rc_r <= CW'(1)) rm_r <= 1'b0;
            end
          end
        end
        BK_REMOVE: begin
          case (rq)
            REQ_FILL: if (ok && ns != '0 && inff_r) begin
              rs_r[w] <= tg; re_r[w] <= tg + 1'b1; st_r[w] <= ns; sm_r[w] <= nstm;
              dt_r[w] <= spl; ep_r[w] <= '0;
              rem_ff_r <= 1'b1; rem_lru_r <= inlru_r; ins_lru_r <= 1'b1;
            end
            REQ_ACCESS: if (ok && st_r[w] != '0) begin
              if (dmd) ep_r[w] <= (sm_r[w] == rstm) ?
                ((ep_r[w] >= EPOCH_MAX) ? EPOCH_MAX : ep_r[w] + 1'b1) : '0;
              if (rstm == source_stream) begin
                if (tg < rs_r[w]) rs_r[w] <= tg;
                else if (tg > re_r[w]) re_r[w] <= tg;
              end
              sm_r[w] <= nstm; dt_r[w] <= spl;
              rem_lru_r <= inlru_r; ins_lru_r <= 1'b1;
            end
            REQ_REPLACE: begin
              if (fc_r != '0) begin out_found <= 1'b1; out_result_way <= WAYF_W'(ff_r[0]); end
              else if (lc_r != '0) begin
                out_found <= 1'b1; out_result_way <= WAYF_W'(lru_r[WI'(lc_r - 1'b1)]);
              end
            end
            REQ_SETSTATE: if (ok && st_r[w] != '0) begin
              sm_r[w] <= nstm;
              if (ns != '0) st_r[w] <= ns;
              else begin
                st_r[w] <= '0; ep_r[w] <= '0;
                rem_lru_r <= inlru_r; app_ff_r <= (fc_r < CW'(WAYS));
              end
            end
            REQ_GET: if (ok) begin
              out_tag <= rs_r[w]; out_region_end <= re_r[w]; out_state <= st_r[w];
              out_stream <= sm_r[w]; out_dirty <= dt_r[w]; out_epoch <= ep_r[w];
            end
            default: ;
          endcase
        end
        BK_INSERT: begin
          // remove from lists, shifting later entries down; append to the free FIFO; insert at MRU
          if (rem_ff_r) begin
            for (int k = 0; k < WAYS - 1; k++) begin
              if (ff_r[k] == w || (k > 0 && pre_ff[k])) ff_r[k] <= ff_r[k+1];
            end
            fc_r <= fc_r - 1'b1;
          end
          if (app_ff_r) begin
            ff_r[WI'(fc_r)] <= w; fc_r <= fc_r + 1'b1;
          end
          if (ins_lru_r) begin
            for (int k = 1; k < WAYS; k++) begin
              if (!lru_past[k-1] || !rem_lru_r) lru_r[k] <= lru_r[k-1];
            end
            lru_r[0] <= w;
            if (!rem_lru_r) lc_r <= lc_r + 1'b1;
          end else if (rem_lru_r) begin
            for (int k = 0; k < WAYS - 1; k++) begin
              if (lru_past[k]) lru_r[k] <= lru_r[k+1];
            end
            lc_r <= lc_r - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < WAYS; k++) begin
      pre_ff[k] = (ff_r[k] == w) || (k > 0 && pre_ff[k > 0 ? k-1 : 0]);
      lru_past[k] = (lru_r[k] == w) || (k > 0 && lru_past[k > 0 ? k-1 : 0]);
    end
  end
endmodule

// ===== hdl/region_lru_replacement_policy_core.sv =====
// A find walks the valid ways from MRU towards LRU until a hit, then decides;
// other requests pass through a remove and an insert step. The back end starts
// the next queued request only after the response to the last one is taken.
// Reset (rst_n low, synchronous): all ways invalid, LRU list empty, free
// FIFO holds ways in ascending order, reach counter and config registers cleared.
// ----------------------------------------------------------------------------
// region_lru_replacement_policy_core
// Region-tracking LRU set with a request queue between front and back end.
// ----------------------------------------------------------------------------
module region_lru_replacement_policy_core #(
  parameter int unsigned WAYS = 16,
  parameter int unsigned STRIDE_LIMIT_LOG2 = 10,
  parameter int unsigned TAG_WIDTH = 48
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [rlru_pkg::REQ_W-1:0] in_req_type,
  input  logic [TAG_WIDTH-1:0] in_tag,
  input  logic [rlru_pkg::WAYF_W-1:0] in_way,
  input  logic [rlru_pkg::STATE_W-1:0] in_new_state,
  input  logic [rlru_pkg::STREAM_W-1:0] in_new_stream,
  input  logic [rlru_pkg::STREAM_W-1:0] in_req_stream,
  input  logic in_is_demand_fill,
  input  logic in_spill,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic out_valid,
  input  logic out_stall,
  output logic out_found,
  output logic [rlru_pkg::WAYF_W-1:0] out_result_way,
  output logic [TAG_WIDTH-1:0] out_tag,
  output logic [TAG_WIDTH-1:0] out_region_end,
  output logic [rlru_pkg::STATE_W-1:0] out_state,
  output logic [rlru_pkg::STREAM_W-1:0] out_stream,
  output logic out_dirty,
  output logic [rlru_pkg::EPOCH_W-1:0] out_epoch
);
  import rlru_pkg::*;
  localparam int unsigned QW = REQ_W + TAG_WIDTH + WAYF_W + STATE_W + 2*STREAM_W + 2;
  localparam logic [0:0] CFG_SRC = 1'b0, CFG_ROM = 1'b1;
  logic [STREAM_W-1:0] src_r;
  logic rom_r;
  logic q_valid, q_pop;
  logic [QW-1:0] q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= '0; rom_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SRC) src_r <= cfg_data;
      if (cfg_index == CFG_ROM) rom_r <= cfg_data[0];
    end
  end

  rlru_front #(.QW(QW)) u_front (
    .clk, .rst_n, .in_valid, .in_stall,
    .in_data({in_req_type, in_tag, in_way, in_new_state, in_new_stream,
              in_req_stream, in_is_demand_fill, in_spill}),
    .q_valid, .q_pop, .q_data
  );

  rlru_back #(.TAG_WIDTH(TAG_WIDTH), .WAYS(WAYS),
              .STRIDE_LIMIT_LOG2(STRIDE_LIMIT_LOG2), .QW(QW)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_data,
    .source_stream(src_r), .replace_on_miss(rom_r),
    .out_valid, .out_stall, .out_found, .out_result_way, .out_tag,
    .out_region_end, .out_state, .out_stream, .out_dirty, .out_epoch
  );
endmodule

// ===== hdl/rlru_checker.sv =====
// ----------------------------------------------------------------------------
// rlru_checker
// Port-level checks of the region LRU core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rlru_checker (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_found,
  input logic [3:0] out_result_way,
  input logic [2:0] out_state
);
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_result_way))
  `CHK_IMPLY(a_way_zero, clk, rst_n, out_valid && !out_found, out_result_way == 4'd0)
  `CHK_IMPLY(a_found_no_state, clk, rst_n, out_valid && out_found, out_state == 3'd0)
  `CHK_NEXT(a_rst_idle, clk, 1'b1, !rst_n, !out_valid && !in_stall)
endmodule

bind region_lru_replacement_policy_core rlru_checker u_chk (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall,
  .out_found, .out_result_way, .out_state
);

// ===== tb/tb_region_lru_replacement_policy_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_region_lru_replacement_policy_core
// Drives find, fill, access, replace, set-state, get and undefined requests into the
// region LRU set, tracks the set contents, LRU order, free FIFO and reach
// counter alongside it, and compares each response field by field.
// ----------------------------------------------------------------------------
module tb_region_lru_replacement_policy_core;
  import rlru_pkg::*;

  localparam int unsigned NW = 16;
  localparam int unsigned TW = 48;
  localparam int unsigned SETTLE = NW + 8;
  localparam int unsigned WATCHDOG = 4000;
  localparam logic [TW-1:0] TAG_ALL1 = {TW{1'b1}};
  localparam logic [0:0] CFG_SRC_STREAM = 1'b0;
  localparam logic [0:0] CFG_REPLACE_ON_MISS = 1'b1;

  typedef struct packed {
    logic [2:0] rt;
    logic [TW-1:0] tag;
    logic [3:0] way;
    logic [2:0] nstate;
    logic [7:0] nstream;
    logic [7:0] rstream;
    logic demand;
    logic spill;
  } request_t;

  typedef struct packed {
    logic found;
    logic [3:0] way;
    logic [TW-1:0] tag;
    logic [TW-1:0] rend;
    logic [2:0] state;
    logic [7:0] stream;
    logic dirty;
    logic [1:0] epoch;
  } response_t;

  typedef struct packed {
    request_t r;
    logic chk;
    response_t e;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [2:0] in_req_type;
  logic [TW-1:0] in_tag;
  logic [3:0] in_way;
  logic [2:0] in_new_state;
  logic [7:0] in_new_stream, in_req_stream;
  logic in_is_demand_fill, in_spill;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [7:0] cfg_data;
  logic out_valid, out_stall;
  logic out_found;
  logic [3:0] out_result_way;
  logic [TW-1:0] out_tag, out_region_end;
  logic [2:0] out_state;
  logic [7:0] out_stream;
  logic out_dirty;
  logic [1:0] out_epoch;

  region_lru_replacement_policy_core DUT (.*);

  // Shadow of the set
  logic [TW-1:0] m_start [NW];
  logic [TW-1:0] m_end [NW];
  logic [2:0] m_state [NW];
  logic [7:0] m_stream [NW];
  logic m_dirty [NW];
  logic [1:0] m_epoch [NW];
  bit m_written [NW];
  logic [3:0] lru_q [$];
  logic [3:0] free_q [$];
  int unsigned reach_cnt;
  bit recycle;
  logic [7:0] src_stream;
  logic replace_on_miss;

  response_t pending_rsp [$];
  int errors;
  int send_gap_pct, stall_pct;
  bit hold_go, hold_done;
  int hold_cnt;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] dist_sat(logic [TW-1:0] a, logic [TW-1:0] b);
    logic [TW-1:0] d;
    d = (a >= b) ? a - b : b - a;
    return (d > 64'hffffffff) ? 64'hffffffff : {16'd0, d};
  endfunction

  function automatic void drop_way(ref logic [3:0] q [$], input logic [3:0] w);
    foreach (q[i]) begin
      if (q[i] == w) begin
        q.delete(i);
        return;
      end
    end
  endfunction

  function automatic bit in_free(logic [3:0] w);
    foreach (free_q[i]) if (free_q[i] == w) return 1;
    return 0;
  endfunction

  function automatic void make_mru(logic [3:0] w);
    drop_way(lru_q, w);
    lru_q.push_front(w);
  endfunction

  function automatic void reach_down();
    if (reach_cnt > 0) reach_cnt--;
  endfunction

  function automatic response_t apply_request(request_t r);
    response_t rsp;
    logic [63:0] best, d, span;
    int nearest, hit;
    logic [3:0] w;
    rsp = '0;
    w = r.way;
    case (r.rt)
      REQ_FIND: begin
        best = 64'hffffffff;
        nearest = -1;
        hit = -1;
        foreach (lru_q[i]) begin
          d = dist_sat(m_start[lru_q[i]], r.tag);
          if (best > d) begin best = d; nearest = lru_q[i]; end
          d = dist_sat(m_end[lru_q[i]], r.tag);
          if (best > d) begin best = d; nearest = lru_q[i]; end
          if (r.tag >= m_start[lru_q[i]] && r.tag <= m_end[lru_q[i]]) begin
            hit = lru_q[i];
            break;
          end
        end
        if (free_q.size() == 0 && hit < 0 && nearest >= 0 && lru_q.size() > 0 &&
            r.rstream == src_stream) begin
          if (reach_cnt < NW && !recycle) begin
            if (best > 64'd4096) begin
              if (nearest == lru_q[0] || nearest == lru_q[$]) reach_cnt++;
              else reach_down();
              if (reach_cnt == NW) recycle = 1;
            end
            if (replace_on_miss) begin
              span = {16'd0, m_end[nearest] - m_start[nearest]};
              if (span + best < 64'd1024) hit = nearest;
            end else begin
              hit = nearest;
            end
          end else begin
            reach_down();
            if (reach_cnt == 0) recycle = 0;
          end
        end
        if (hit >= 0) begin
          rsp.found = 1;
          rsp.way = hit[3:0];
        end
      end
      REQ_FILL: begin
        if (r.nstate != 0 && in_free(w)) begin
          drop_way(free_q, w);
          m_start[w] = r.tag;
          m_end[w] = r.tag + 1'b1;
          m_state[w] = r.nstate;
          m_stream[w] = r.nstream;
          m_dirty[w] = r.spill;
          m_epoch[w] = 0;
          m_written[w] = 1;
          make_mru(w);
        end
      end
      REQ_ACCESS: begin
        if (m_state[w] != 0) begin
          if (r.demand) begin
            if (m_stream[w] == r.rstream)
              m_epoch[w] = (m_epoch[w] == EPOCH_MAX) ? EPOCH_MAX : m_epoch[w] + 1'b1;
            else
              m_epoch[w] = 0;
          end
          if (r.rstream == src_stream) begin
            if (r.tag < m_start[w]) m_start[w] = r.tag;
            else if (r.tag > m_end[w]) m_end[w] = r.tag;
          end
          m_stream[w] = r.nstream;
          m_dirty[w] = r.spill;
          make_mru(w);
        end
      end
      REQ_REPLACE: begin
        if (free_q.size() > 0) begin
          rsp.found = 1;
          rsp.way = free_q[0];
        end else if (lru_q.size() > 0) begin
          rsp.found = 1;
          rsp.way = lru_q[$];
        end
      end
      REQ_SETSTATE: begin
        if (m_state[w] != 0) begin
          m_stream[w] = r.nstream;
          if (r.nstate != 0) begin
            m_state[w] = r.nstate;
          end else begin
            m_state[w] = 0;
            m_epoch[w] = 0;
            drop_way(lru_q, w);
            if (free_q.size() < NW) free_q.push_back(w);
          end
        end
      end
      REQ_GET: begin
        rsp.tag = m_start[w];
        rsp.rend = m_end[w];
        rsp.state = m_state[w];
        rsp.stream = m_stream[w];
        rsp.dirty = m_dirty[w];
        rsp.epoch = m_epoch[w];
      end
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic send(request_t r, logic chk, response_t e);
    response_t p;
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= r.rt;
    in_tag <= r.tag;
    in_way <= r.way;
    in_new_state <= r.nstate;
    in_new_stream <= r.nstream;
    in_req_stream <= r.rstream;
    in_is_demand_fill <= r.demand;
    in_spill <= r.spill;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = apply_request(r);
    pending_rsp.push_back(chk ? e : p);
  endtask

  task automatic write_cfg(logic [7:0] src, logic rom);
    in_valid <= 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SRC_STREAM;
    cfg_data <= src;
    @(posedge clk);
    cfg_index <= CFG_REPLACE_ON_MISS;
    cfg_data <= {7'($urandom_range(127)), rom};
    @(posedge clk);
    cfg_we <= 1'b0;
    src_stream = src;
    replace_on_miss = rom;
  endtask

  function automatic logic [TW-1:0] pick_tag();
    int k;
    k = $urandom_range(99);
    if (k < 5) return TAG_ALL1 - TW'($urandom_range(3));
    if (k < 10) return TW'($urandom_range(3));
    if (k < 20) return TW'({$urandom, $urandom});
    return TW'($urandom_range(7) * 12288 + $urandom_range(5000));
  endfunction

  function automatic logic [3:0] pick_valid_way();
    if (lru_q.size() > 0 && $urandom_range(9) < 8) return lru_q[$urandom_range(lru_q.size() - 1)];
    return 4'($urandom_range(15));
  endfunction

  function automatic request_t random_request();
    request_t r;
    int k;
    logic [3:0] cand [$];
    r.tag = pick_tag();
    r.way = 4'($urandom_range(15));
    r.nstate = 3'($urandom_range(7));
    r.nstream = 8'($urandom_range(255));
    r.rstream = ($urandom_range(9) < 6) ? src_stream : 8'($urandom_range(255));
    r.demand = 1'($urandom_range(1));
    r.spill = 1'($urandom_range(1));
    k = $urandom_range(99);
    if (k < 30) begin
      r.rt = REQ_FIND;
    end else if (k < 48) begin
      r.rt = REQ_ACCESS;
      r.way = pick_valid_way();
    end else if (k < 63) begin
      r.rt = REQ_FILL;
      if (free_q.size() > 0 && $urandom_range(9) < 7) r.way = free_q[0];
      if ($urandom_range(9) < 8 && r.nstate == 0) r.nstate = 3'($urandom_range(1, 7));
    end else if (k < 70) begin
      r.rt = REQ_REPLACE;
    end else if (k < 80) begin
      r.rt = REQ_SETSTATE;
      r.way = pick_valid_way();
      // keep the set mostly full so full-set misses are reached
      if (r.nstate == 0 && $urandom_range(2) != 0) r.nstate = 3'($urandom_range(1, 7));
    end else if (k < 95) begin
      r.rt = REQ_GET;
      foreach (m_written[i]) if (m_written[i]) cand.push_back(4'(i));
      if (cand.size() == 0) r.rt = REQ_REPLACE;
      else r.way = cand[$urandom_range(cand.size() - 1)];
    end else begin
      r.rt = 3'($urandom_range(6, 7));
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      errors++;
    end
  endtask

  // Response side: watchdog, stall pattern, long hold-off and checking
  always @(posedge clk) begin
    response_t e;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("region_lru_replacement_policy_core regression: fail");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        check_field("found", 64'(e.found), 64'(out_found));
        check_field("result_way", 64'(e.way), 64'(out_result_way));
        check_field("tag", 64'(e.tag), 64'(out_tag));
        check_field("region_end", 64'(e.rend), 64'(out_region_end));
        check_field("state", 64'(e.state), 64'(out_state));
        check_field("stream", 64'(e.stream), 64'(out_stream));
        check_field("dirty", 64'(e.dirty), 64'(out_dirty));
        check_field("epoch", 64'(e.epoch), 64'(out_epoch));
      end
    end
    if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 300;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    row_t rows [$];
    request_t r;
    response_t z;
    int modes_send [4] = '{0, 49, 0, 7};
    int modes_stall [4] = '{0, 0, 49, 7};
    logic [7:0] src_set [6] = '{8'h00, 8'hff, 8'h5a, 8'h5a, 8'h00, 8'hff};
    logic rom_set [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

    errors = 0;
    hold_go = 0;
    send_gap_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    {in_req_type, in_tag, in_way, in_new_state} = '0;
    {in_new_stream, in_req_stream, in_is_demand_fill, in_spill} = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < NW; i++) begin
      m_start[i] = 0; m_end[i] = 0; m_state[i] = 0; m_stream[i] = 0;
      m_dirty[i] = 0; m_epoch[i] = 0; m_written[i] = 0;
      free_q.push_back(4'(i));
    end
    reach_cnt = 0;
    recycle = 0;
    src_stream = 0;
    replace_on_miss = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_cfg(8'h00, 1'b0);

    z = '0;
    // rt, tag, way, nstate, nstream, rstream, demand, spill | chk | expected
    rows.push_back('{'{REQ_REPLACE, 48'h0, 4'd0, 3'd0, 8'h0, 8'h0, 1'b0, 1'b0}, 1'b1,
                     '{1'b1, 4'd0, 48'h0, 48'h0, 3'd0, 8'h0, 1'b0, 2'd0}});
    rows.push_back('{'{REQ_FIND, TAG_ALL1, 4'd15, 3'd7, 8'hff, 8'h00, 1'b1, 1'b1}, 1'b1, z});
    rows.push_back('{'{3'd6, TAG_ALL1, 4'd15, 3'd7, 8'hff, 8'hff, 1'b1, 1'b1}, 1'b1, z});
    rows.push_back('{'{3'd7, 48'h0, 4'd0, 3'd0, 8'h0, 8'h0, 1'b0, 1'b0}, 1'b1, z});
    rows.push_back('{'{REQ_FILL, 48'h5, 4'd1, 3'd0, 8'h1, 8'h0, 1'b0, 1'b1}, 1'b1, z});
    rows.push_back('{'{REQ_FILL, TAG_ALL1, 4'd0, 3'd7, 8'hff, 8'h0, 1'b0, 1'b1}, 1'b1, z});
    rows.push_back('{'{REQ_GET, 48'h0, 4'd0, 3'd0, 8'h0, 8'h0, 1'b0, 1'b0}, 1'b1,
                     '{1'b0, 4'd0, TAG_ALL1, 48'h0, 3'd7, 8'hff, 1'b1, 2'd0}});
    rows.push_back('{'{REQ_FILL, 48'h100, 4'd0, 3'd3, 8'h1, 8'h0, 1'b0, 1'b0}, 1'b1, z});
    rows.push_back('{'{REQ_REPLACE, 48'h0, 4'd0, 3'd0, 8'h0, 8'h0, 1'b0, 1'b0}, 1'b1,
                     '{1'b1, 4'd1, 48'h0, 48'h0, 3'd0, 8'h0, 1'b0, 2'd0}});
    rows.push_back('{'{REQ_ACCESS, 48'h0, 4'd9, 3'd0, 8'h3, 8'h0, 1'b1, 1'b0}, 1'b1, z});
    rows.push_back('{'{REQ_SETSTATE, 48'h0, 4'd9, 3'd0, 8'h3, 8'h0, 1'b0, 1'b0}, 1'b1, z});
    rows.push_back('{'{REQ_FILL, 48'h1000, 4'd1, 3'd1, 8'h00, 8'h0, 1'b0, 1'b0}, 1'b1, z});
    rows.push_back('{'{REQ_ACCESS, 48'h0800, 4'd1, 3'd0, 8'h00, 8'h00, 1'b1, 1'b1}, 1'b1, z});
    rows.push_back('{'{REQ_ACCESS, 48'h1800, 4'd1, 3'd0, 8'h00, 8'h00, 1'b1, 1'b0}, 1'b1, z});
    rows.push_back('{'{REQ_ACCESS, 48'h1000, 4'd1, 3'd0, 8'h00, 8'h00, 1'b1, 1'b0}, 1'b1, z});
    rows.push_back('{'{REQ_ACCESS, 48'h1000, 4'd1, 3'd0, 8'h00, 8'h00, 1'b1, 1'b0}, 1'b1, z});
    rows.push_back('{'{REQ_GET, 48'h0, 4'd1, 3'd0, 8'h0, 8'h0, 1'b0, 1'b0}, 1'b1,
                     '{1'b0, 4'd0, 48'h0800, 48'h1800, 3'd1, 8'h00, 1'b0, 2'd3}});
    rows.push_back('{'{REQ_ACCESS, 48'h1000, 4'd1, 3'd0, 8'h07, 8'h44, 1'b1, 1'b0}, 1'b0, z});
    rows.push_back('{'{REQ_FIND, 48'h1234, 4'd0, 3'd0, 8'h0, 8'h00, 1'b0, 1'b0}, 1'b1,
                     '{1'b1, 4'd1, 48'h0, 48'h0, 3'd0, 8'h0, 1'b0, 2'd0}});
    rows.push_back('{'{REQ_FIND, 48'h9000, 4'd0, 3'd0, 8'h0, 8'h00, 1'b0, 1'b0}, 1'b0, z});
    rows.push_back('{'{REQ_SETSTATE, 48'hdead, 4'd0, 3'd5, 8'h21, 8'h0, 1'b0, 1'b0}, 1'b0, z});
    rows.push_back('{'{REQ_SETSTATE, 48'h0, 4'd1, 3'd0, 8'h22, 8'h0, 1'b0, 1'b0}, 1'b0, z});
    rows.push_back('{'{REQ_GET, 48'h0, 4'd1, 3'd0, 8'h0, 8'h0, 1'b0, 1'b0}, 1'b0, z});
    foreach (rows[i]) send(rows[i].r, rows[i].chk, rows[i].e);

    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(src_set[ph], rom_set[ph]);
      send_gap_pct = modes_send[ph % 4];
      stall_pct = modes_stall[ph % 4];
      if (ph == 2) hold_go = 1;
      for (int n = 0; n < 230; n++) begin
        r = random_request();
        send(r, 1'b0, z);
      end
    end
    in_valid <= 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0)
      $display("region_lru_replacement_policy_core regression: pass");
    else
      $display("region_lru_replacement_policy_core regression: fail");
    $finish;
  end
endmodule
